### design/ppg_pkg.sv
// Shared types, constants and the sine table function for the plasma pixel generator.
// Used by ppg_sqrt_cell, ppg_sine_rom and plasma_pixel_generator_unit. No dependencies.
package ppg_pkg;

  localparam int unsigned X_W      = 9;
  localparam int unsigned Y_W      = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned M_W      = 14;   // sine argument m, angle is m/256 rad
  localparam int unsigned WORD_W   = 17;   // sine ROM word, 0..65536
  localparam int unsigned SUM_W    = 19;   // sum of four words
  localparam int unsigned SQ_W     = 28;   // radicand / root working width
  localparam int unsigned SQRT_STEPS = 14; // one cell per root bit
  localparam int unsigned RAD_W    = 14;

  // ROM depths for each term
  localparam int unsigned X_DEPTH   = 512;   // W(8x)
  localparam int unsigned Y_DEPTH   = 256;   // W(16y)
  localparam int unsigned XY_DEPTH  = 767;   // W(8(x+y)), x+y <= 766
  localparam int unsigned RAD_DEPTH = 9138;  // W(r16), r16 <= isqrt(256*(511^2+255^2))
  localparam int unsigned XY_W      = 10;

  localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [WORD_W-1:0] word_t;

  // one word moving down the square-root chain
  typedef struct packed {
    logic             vld;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [SQ_W-1:0]  rem;
    logic [SQ_W-1:0]  root;
  } sqrt_word_t;

  // 128 + 128*sin(m/256) in units of 2^-8; evaluated only at elaboration
  function automatic word_t sine_word(input logic [M_W-1:0] m);
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] v;
    logic [63:0] r;
    logic signed [63:0] s;
    logic neg;
    a = {2'b00, m, 48'd0};
    q = a / HALF_PI_Q56;
    f = a - q * HALF_PI_Q56;
    neg = q[1];
    if (q[0]) begin
      f = HALF_PI_Q56 - f;
    end
    t = f >> 26;
    t2 = (t * t) >> 30;
    term = t;
    s = $signed(t);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * t2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 1) begin
        s = s - $signed(term);
      end else begin
        s = s + $signed(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if ($unsigned(s) > ONE_Q30) begin
      s = $signed(ONE_Q30);
    end
    v = neg ? ONE_Q30 - $unsigned(s) : ONE_Q30 + $unsigned(s);
    r = (v + (64'd1 << 14)) >> 15;
    return r[WORD_W-1:0];
  endfunction

endpackage

### design/ppg_sqrt_cell.sv
// One step of the digit-by-digit integer square root, registered.
// Depends on ppg_pkg (sqrt_word_t).
module ppg_sqrt_cell
  import ppg_pkg::*;
#(
  parameter int unsigned LEVEL = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sqrt_word_t word_i,
  output sqrt_word_t word_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * LEVEL);

  sqrt_word_t word_r;
  sqrt_word_t word_nxt;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial    = word_i.root + BIT;
    word_nxt = word_i;
    if (word_i.rem >= trial) begin
      word_nxt.rem  = word_i.rem - trial;
      word_nxt.root = (word_i.root >> 1) + BIT;
    end else begin
      word_nxt.root = word_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

### design/ppg_sine_rom.sv
// Sine table ROM, entry i holds the word for m = i*STEP, registered read.
// Depends on ppg_pkg (sine_word, word_t).
module ppg_sine_rom
  import ppg_pkg::*;
#(
  parameter int unsigned DEPTH = X_DEPTH,
  parameter int unsigned STEP  = 8
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output word_t                    rd_data
);

  word_t rom [DEPTH];
  word_t rd_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = sine_word(M_W'(i * STEP));
  end

  always_ff @(posedge clk) begin
    rd_r <= rom[addr];
  end

  assign rd_data = rd_r;

endmodule

### design/plasma_pixel_generator_unit.sv
// Plasma pixel generator: one coordinate in, one palette index out, per clock.
// Pipeline: out_valid pulses after the edge that takes start, once the word has passed the squares, radicand,
// 14-cell square-root chain with one root bit per cell, ROM read and output register stages.
// busy stays low, so a new word is taken every cycle. The receiver cannot stall.
// Synchronous active-low reset clears the valid pipeline and palette_shift; no clearing
// pass. Depends on ppg_pkg and the cell/ROM modules.
module plasma_pixel_generator_unit
  import ppg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [X_W-1:0]   in_pixel_x,
  input  logic [Y_W-1:0]   in_pixel_y,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_palette_index,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_palette_shift
);

  logic [IDX_W-1:0] shift_r;

  // stage A: squares
  logic             a_vld_r;
  logic [X_W-1:0]   a_x_r;
  logic [Y_W-1:0]   a_y_r;
  logic [2*X_W-1:0] a_xx_r;
  logic [2*Y_W-1:0] a_yy_r;

  // stage B feeds the chain
  sqrt_word_t       b_word_r;
  sqrt_word_t       b_word_nxt;
  logic [SUM_W-1:0] b_n;

  sqrt_word_t chain [SQRT_STEPS+1];
  sqrt_word_t tail;

  logic             rom_vld_r;
  logic [XY_W-1:0]  xy_addr;
  word_t            w_x;
  word_t            w_y;
  word_t            w_xy;
  word_t            w_rad;
  logic [SUM_W-1:0] sum;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_index_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      shift_r <= cfg_palette_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
    a_x_r  <= in_pixel_x;
    a_y_r  <= in_pixel_y;
    a_xx_r <= in_pixel_x * in_pixel_x;
    a_yy_r <= in_pixel_y * in_pixel_y;
  end

  always_comb begin
    b_n             = SUM_W'(a_xx_r) + SUM_W'(a_yy_r);
    b_word_nxt.vld  = a_vld_r;
    b_word_nxt.x    = a_x_r;
    b_word_nxt.y    = a_y_r;
    b_word_nxt.rem  = {(SQ_W - SUM_W - 8)'(0), b_n, 8'd0};  // 256*(x^2+y^2)
    b_word_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_word_r.vld <= 1'b0;
    end else begin
      b_word_r <= b_word_nxt;
    end
  end

  assign chain[0] = b_word_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
    ppg_sqrt_cell #(
      .LEVEL (SQRT_STEPS - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (chain[i]),
      .word_o (chain[i+1])
    );
  end

  assign tail    = chain[SQRT_STEPS];
  assign xy_addr = XY_W'(tail.x) + XY_W'(tail.y);

  ppg_sine_rom #(.DEPTH(X_DEPTH), .STEP(8)) u_rom_x (
    .clk     (clk),
    .addr    (tail.x),
    .rd_data (w_x)
  );

  ppg_sine_rom #(.DEPTH(Y_DEPTH), .STEP(16)) u_rom_y (
    .clk     (clk),
    .addr    (tail.y),
    .rd_data (w_y)
  );

  ppg_sine_rom #(.DEPTH(XY_DEPTH), .STEP(8)) u_rom_xy (
    .clk     (clk),
    .addr    (xy_addr),
    .rd_data (w_xy)
  );

  ppg_sine_rom #(.DEPTH(RAD_DEPTH), .STEP(1)) u_rom_rad (
    .clk     (clk),
    .addr    (tail.root[RAD_W-1:0]),
    .rd_data (w_rad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_vld_r <= 1'b0;
    end else begin
      rom_vld_r <= tail.vld;
    end
  end

  assign sum = (SUM_W'(w_x) + SUM_W'(w_y)) + (SUM_W'(w_xy) + SUM_W'(w_rad));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rom_vld_r;
    end
    // plasma = sum/1024, wraps with the shift
    out_index_r <= sum[17:10] + shift_r;
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_index_r;

endmodule

### verif/testbench.sv
// Testbench for plasma_pixel_generator_unit: directed corner pixels, shift-wrap checks, then random pixels.
// Builds its own sine word table and square root to predict every palette index.
// Depends on ppg_pkg and the design sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppg_pkg::*;

  localparam int unsigned LUT_DEPTH = 1 << M_W;
  localparam int unsigned DRAIN_CYCLES = 30;   // idle clocks after the expected queue empties

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [X_W-1:0]   in_pixel_x = '0;
  logic [Y_W-1:0]   in_pixel_y = '0;
  logic             out_valid;
  logic [IDX_W-1:0] out_palette_index;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_palette_shift = '0;

  word_t            sine_words [LUT_DEPTH];
  logic [IDX_W-1:0] cur_shift = '0;
  logic [IDX_W-1:0] expected_index_q [$];
  int unsigned      mismatches = 0;
  bit               idle_en = 1'b1;
  logic [X_W-1:0]   peak_x, dip_x;
  logic [Y_W-1:0]   peak_y, dip_y;

  plasma_pixel_generator_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_palette_index(out_palette_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_palette_shift(cfg_palette_shift)
  );

  always #5 clk = ~clk;

  // 128 + 128*sin(ang/256) in 2^-8 units, Taylor series in Q30
  function automatic word_t calc_sine_word(input logic [M_W-1:0] ang);
    logic [63:0] scaled;
    logic [63:0] quad;
    logic [63:0] frac;
    logic [63:0] t;
    logic [63:0] t_sq;
    logic [63:0] term;
    logic [63:0] level;
    logic [63:0] rounded;
    logic signed [63:0] acc;
    scaled = {2'b00, ang, 48'd0};
    quad = scaled / HALF_PI_Q56;
    frac = scaled - quad * HALF_PI_Q56;
    if (quad[0]) begin
      frac = HALF_PI_Q56 - frac;
    end
    t = frac >> 26;
    t_sq = (t * t) >> 30;
    term = t;
    acc = $signed(t);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * t_sq) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if ($unsigned(acc) > ONE_Q30) begin
      acc = $signed(ONE_Q30);
    end
    level = quad[1] ? ONE_Q30 - $unsigned(acc) : ONE_Q30 + $unsigned(acc);
    rounded = (level + (64'd1 << 14)) >> 15;
    return rounded[WORD_W-1:0];
  endfunction

  // truncating root, built one bit at a time from the top
  function automatic logic [RAD_W-1:0] radius16(input logic [X_W-1:0] px,
                                                input logic [Y_W-1:0] py);
    logic [31:0] radicand;
    logic [31:0] trial;
    logic [RAD_W-1:0] root;
    radicand = 32'd256 * (32'(px) * 32'(px) + 32'(py) * 32'(py));
    root = '0;
    for (int b = RAD_W - 1; b >= 0; b--) begin
      trial = 32'(root | (RAD_W'(1) << b));
      if (trial * trial <= radicand) begin
        root = RAD_W'(trial);
      end
    end
    return root;
  endfunction

  function automatic logic [8:0] plasma_value(input logic [X_W-1:0] px,
                                             input logic [Y_W-1:0] py);
    logic [SUM_W-1:0] total;
    total = SUM_W'(sine_words[M_W'(8 * 32'(px))])
          + SUM_W'(sine_words[M_W'(16 * 32'(py))])
          + SUM_W'(sine_words[M_W'(8 * (32'(px) + 32'(py)))])
          + SUM_W'(sine_words[radius16(px, py)]);
    return total[SUM_W-1:10];
  endfunction

  function automatic logic [IDX_W-1:0] predict_palette_index(input logic [X_W-1:0] px,
                                                             input logic [Y_W-1:0] py);
    logic [8:0] wrapped;
    wrapped = plasma_value(px, py) + 9'(cur_shift);
    return wrapped[IDX_W-1:0];
  endfunction

  // result checker: the receiver never stalls, every strobe is a word
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_index_q.size() == 0) begin
        $error("palette_index word with nothing expected: got %0d", out_palette_index);
        mismatches++;
      end else begin
        if (out_palette_index !== expected_index_q[0]) begin
          $error("palette_index mismatch: expected %0d, got %0d",
                 expected_index_q[0], out_palette_index);
          mismatches++;
        end
        void'(expected_index_q.pop_front());
      end
    end
  end

  task automatic write_shift(input logic [IDX_W-1:0] shift);
    cfg_valid <= 1'b1;
    cfg_palette_shift <= shift;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_shift = shift;
  endtask

  // leaves start high; the caller lowers it for a gap or at the end
  task automatic send_pixel(input logic [X_W-1:0] px, input logic [Y_W-1:0] py);
    start <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (busy);
    expected_index_q.push_back(predict_palette_index(px, py));
  endtask

  task automatic maybe_gap();
    if (idle_en && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic send_and_gap(input logic [X_W-1:0] px, input logic [Y_W-1:0] py);
    send_pixel(px, py);
    maybe_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_index_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic find_extreme_pixels();
    logic [8:0] val;
    logic [8:0] hi;
    logic [8:0] lo;
    hi = '0;
    lo = '1;
    for (int xi = 0; xi < (1 << X_W); xi++) begin
      for (int yi = 0; yi < (1 << Y_W); yi++) begin
        val = plasma_value(X_W'(xi), Y_W'(yi));
        if (val > hi) begin
          hi = val;
          peak_x = X_W'(xi);
          peak_y = Y_W'(yi);
        end
        if (val < lo) begin
          lo = val;
          dip_x = X_W'(xi);
          dip_y = Y_W'(yi);
        end
      end
    end
  endtask

  // reset value of the shift is 0: no write before this test
  task automatic test_corner_pixels();
    send_and_gap(0, 0);
    send_and_gap(511, 255);
    send_and_gap(319, 199);
    send_and_gap(320, 200);
    send_and_gap(511, 0);
    send_and_gap(0, 255);
    send_and_gap(1, 1);
    send_and_gap(256, 128);
    send_and_gap(255, 127);
    send_and_gap(50, 25);
    send_and_gap(peak_x, peak_y);
    send_and_gap(dip_x, dip_y);
    drain();
  endtask

  // peak plus a full shift forces the 8-bit wrap
  task automatic test_shift_wrap();
    write_shift(8'd255);
    send_and_gap(peak_x, peak_y);
    send_and_gap(dip_x, dip_y);
    send_and_gap(511, 255);
    send_and_gap(0, 0);
    drain();
    write_shift(8'd128);
    send_and_gap(peak_x, peak_y);
    send_and_gap(dip_x, dip_y);
    send_and_gap(170, 85);
    drain();
    write_shift(8'd1);
    send_and_gap(peak_x, peak_y);
    send_and_gap(0, 0);
    drain();
  endtask

  task automatic test_random_pixels(input int unsigned count,
                                    input logic [IDX_W-1:0] shift,
                                    input bit gaps);
    idle_en = gaps;
    write_shift(shift);
    repeat (count) begin
      if ($urandom_range(3) != 0) begin
        // mostly stay on the visible screen
        send_and_gap(X_W'($urandom_range(319)), Y_W'($urandom_range(199)));
      end else begin
        send_and_gap(X_W'($urandom_range(511)), Y_W'($urandom_range(255)));
      end
    end
    drain();
    idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < LUT_DEPTH; i++) begin
      sine_words[i] = calc_sine_word(M_W'(i));
    end
    find_extreme_pixels();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_pixels();
    test_shift_wrap();
    test_random_pixels(150, 8'd0, 1'b1);
    test_random_pixels(150, 8'd255, 1'b1);
    test_random_pixels(200, IDX_W'($urandom_range(255)), 1'b0);
    test_random_pixels(150, IDX_W'($urandom_range(255)), 1'b1);
    test_random_pixels(150, IDX_W'($urandom_range(255)), 1'b1);
    test_random_pixels(100, 8'd127, 1'b1);
    if (mismatches == 0 && expected_index_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (expected_index_q.size() != 0) begin
        $error("%0d palette_index words never arrived", expected_index_q.size());
      end
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("simulation failed");
    $finish;
  end

endmodule
